@@ hw/rtl/crwa_pkg.sv @@
// Shared constants for the counter rate / window average block.
// Field widths, register indexes and arithmetic constants. No dependencies.
package crwa_pkg;

  localparam int NIC_MAX_DEF    = 8;
  localparam int WINDOW_MAX_DEF = 16;

  localparam int NIC_W    = 3;
  localparam int CNT_W    = 64;
  localparam int RATE_W   = 48;
  localparam int PERIOD_W = 16;
  localparam int WIN_W    = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [WIN_W-1:0]    WINDOW_RST = 5'd16;

  // hundredths of a unit per second for one unit per millisecond
  localparam int MUL_W = 49;
  localparam logic [MUL_W-1:0] HUND_PER_MS = 49'd100000;

  // shared divider: dividend/quotient width and divisor width
  localparam int DIV_W   = 83;
  localparam int DSR_W   = 17;
  localparam int DCNT_W  = 7;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

endpackage

@@ hw/rtl/counter_rate_window_average_top.sv @@
// Top level of the counter rate / window average block.
// Uses crwa_pkg; holds the counter and rate-history memories and the shared divider.
//
// Each transfer on the input channel carries the four free-running counters of one
// interface and yields one result transfer with four rates (hundredths per second,
// rounded, saturating at 2^48-1) and four window averages (truncated). Items are
// handled one at a time: a counter takes a read-modify-write of the previous-value
// memory, two 32x17 multiply steps, an 83-bit bit-serial division for the rate, one
// history write, F history reads (F = fill count) and, when F > 0, a division of
// 48+clog2(WINDOW_MAX+1) bits for the average. Both divisions use the one shared
// restoring divider, and a finished item waits for the output register to free up.
// The result sits in an output register, so the next item is taken as soon as the
// result is parked there. After reset the block sweeps the history memory and the
// counter memory, one entry a cycle over the NIC_MAX*4*WINDOW_MAX history entries
// (512 at defaults), and accepts no item until the sweep ends; configuration writes
// are taken at any time but must only be issued while the block is idle. A nic_index
// at or above NIC_MAX gives all-zero rates and averages and leaves counter state
// alone; its round_end still counts.
module counter_rate_window_average_top
  import crwa_pkg::*;
#(
  parameter int NIC_MAX    = NIC_MAX_DEF,
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NIC_W-1:0]      in_nic_index,
  input  logic [CNT_W-1:0]      in_recv_bytes,
  input  logic [CNT_W-1:0]      in_recv_packets,
  input  logic [CNT_W-1:0]      in_send_bytes,
  input  logic [CNT_W-1:0]      in_send_packets,
  input  logic                  in_round_end,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NIC_W-1:0]      out_nic_index,
  output logic [RATE_W-1:0]     out_recv_bytes_rate,
  output logic [RATE_W-1:0]     out_recv_packets_rate,
  output logic [RATE_W-1:0]     out_send_bytes_rate,
  output logic [RATE_W-1:0]     out_send_packets_rate,
  output logic [RATE_W-1:0]     out_recv_bytes_avg,
  output logic [RATE_W-1:0]     out_recv_packets_avg,
  output logic [RATE_W-1:0]     out_send_bytes_avg,
  output logic [RATE_W-1:0]     out_send_packets_avg
);

  localparam int PDEPTH = NIC_MAX * 4;
  localparam int HDEPTH = NIC_MAX * 4 * WINDOW_MAX;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int HAW    = $clog2(HDEPTH);
  localparam int FW     = $clog2(WINDOW_MAX + 1);
  localparam int PW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW     = RATE_W + FW;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_PREV     = 10'b0000000100,
    S_MUL_LO   = 10'b0000001000,
    S_MUL_HI   = 10'b0000010000,
    S_DIV_RATE = 10'b0000100000,
    S_HIST_WR  = 10'b0001000000,
    S_SUM      = 10'b0010000000,
    S_DIV_AVG  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state_r;

  // configuration
  logic [PERIOD_W-1:0] period_r;
  logic [WIN_W-1:0]    win_r;

  // round state
  logic [PW-1:0] pos_r;
  logic [FW-1:0] fill_r;

  // latched item
  logic [NIC_W-1:0] nic_r;
  logic             nic_ok_r;
  logic             round_end_r;
  logic [CNT_W-1:0] cnt_r [4];
  logic [1:0]       ch_r;

  // per-counter results
  logic [RATE_W-1:0] rate_r [4];
  logic [RATE_W-1:0] avg_r  [4];

  // arithmetic
  logic [CNT_W/2-1:0] delta_hi_r;
  logic [DIV_W-1:0]   acc_r;
  logic [SW-1:0]      sum_r;
  logic [FW-1:0]      sum_idx_r;
  logic               pend_r;

  // divider
  logic [DIV_W-1:0]  div_q_r;
  logic [DSR_W:0]    div_rem_r;
  logic [DSR_W-1:0]  div_dsr_r;
  logic [DCNT_W-1:0] div_cnt_r;

  // clearing sweep
  logic [HAW-1:0] clr_cnt_r;

  // memories
  logic [CNT_W-1:0]  prev_mem [PDEPTH];
  logic [RATE_W-1:0] hist_mem [HDEPTH];
  logic [CNT_W-1:0]  prev_rd_r;
  logic [RATE_W-1:0] hist_rd_r;

  // output register
  logic              out_valid_r;
  logic [NIC_W-1:0]  out_nic_r;
  logic [RATE_W-1:0] out_rate_r [4];
  logic [RATE_W-1:0] out_avg_r  [4];

  // ---------------------------------------------------------------------------
  // Derived values
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0] p_eff;
  logic [FW-1:0]       w_eff;
  logic [PAW-1:0]      slot;
  logic [HAW-1:0]      hist_base;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W-1:0]    delta;
  logic [MUL_W-1:0]    prod_lo;
  logic [MUL_W-1:0]    prod_hi;
  logic [RATE_W-1:0]   rate_v;
  logic [FW-1:0]       pos_inc;

  // zero period acts as one; window clamped to 1..WINDOW_MAX
  assign p_eff = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign w_eff = (win_r == '0) ? FW'(1) :
                 ((32'(win_r) > WINDOW_MAX) ? FW'(WINDOW_MAX) : FW'(win_r));

  assign slot      = PAW'({nic_r, ch_r});
  assign hist_base = HAW'(slot) * HAW'(WINDOW_MAX);
  assign cur_cnt   = cnt_r[ch_r];
  assign delta     = cur_cnt - prev_rd_r;
  assign prod_lo   = MUL_W'(delta[CNT_W/2-1:0]) * HUND_PER_MS;
  assign prod_hi   = MUL_W'(delta_hi_r) * HUND_PER_MS;
  assign rate_v    = (|div_q_r[DIV_W-1:RATE_W]) ? RATE_MAX : div_q_r[RATE_W-1:0];
  assign pos_inc   = FW'(pos_r) + FW'(1);

  // divider step: shift in one dividend bit, subtract when it fits
  logic [DSR_W:0]   rem_sh;
  logic             q_bit;
  logic [DSR_W:0]   div_rem_nxt;
  logic [DIV_W-1:0] div_q_nxt;

  always_comb begin
    rem_sh      = {div_rem_r[DSR_W-1:0], div_q_r[DIV_W-1]};
    q_bit       = (rem_sh >= {1'b0, div_dsr_r});
    div_rem_nxt = q_bit ? (rem_sh - {1'b0, div_dsr_r}) : rem_sh;
    div_q_nxt   = {div_q_r[DIV_W-2:0], q_bit};
  end

  // ---------------------------------------------------------------------------
  // Memory ports
  // ---------------------------------------------------------------------------
  logic             prev_we;
  logic [PAW-1:0]   prev_wa;
  logic [CNT_W-1:0] prev_wd;
  logic             hist_we;
  logic [HAW-1:0]   hist_wa;
  logic [RATE_W-1:0] hist_wd;
  logic [HAW-1:0]   hist_ra;

  always_comb begin
    prev_we = 1'b0;
    prev_wa = slot;
    prev_wd = cur_cnt;
    hist_we = 1'b0;
    hist_wa = hist_base + HAW'(pos_r);
    hist_wd = rate_v;
    if (state_r == S_CLEAR) begin
      // sweep both memories; the counter memory is the shorter one
      hist_we = 1'b1;
      hist_wa = clr_cnt_r;
      hist_wd = '0;
      prev_we = (32'(clr_cnt_r) < PDEPTH);
      prev_wa = PAW'(clr_cnt_r);
      prev_wd = '0;
    end else if (state_r == S_PREV) begin
      prev_we = nic_ok_r;
    end else if (state_r == S_HIST_WR) begin
      hist_we = 1'b1;
    end
  end

  assign hist_ra = hist_base + HAW'(sum_idx_r);

  // read before write on the same entry returns the old counter value
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd_r <= prev_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_r <= hist_mem[hist_ra];
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      period_r    <= PERIOD_RST;
      win_r       <= WINDOW_RST;
      pos_r       <= '0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      sum_idx_r   <= '0;
      div_cnt_r   <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes: unknown indexes drop
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD_MS:   period_r <= cfg_wdata[PERIOD_W-1:0];
          REG_WINDOW_SIZE: win_r    <= cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end

      // a result parked in the same cycle keeps the register full
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + HAW'(1);
          if (32'(clr_cnt_r) == HDEPTH - 1) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_xfer) begin
            nic_r       <= in_nic_index;
            nic_ok_r    <= (32'(in_nic_index) < NIC_MAX);
            round_end_r <= in_round_end;
            cnt_r[0]    <= in_recv_bytes;
            cnt_r[1]    <= in_recv_packets;
            cnt_r[2]    <= in_send_bytes;
            cnt_r[3]    <= in_send_packets;
            for (int i = 0; i < 4; i++) begin
              rate_r[i] <= '0;
              avg_r[i]  <= '0;
            end
            ch_r    <= '0;
            state_r <= S_PREV;
          end
        end

        S_PREV: begin
          // out-of-range interface: results stay zero
          state_r <= nic_ok_r ? S_MUL_LO : S_DONE;
        end

        S_MUL_LO: begin
          delta_hi_r <= delta[CNT_W-1:CNT_W/2];
          acc_r      <= (DIV_W'(prod_lo) << 1) + DIV_W'(p_eff);
          state_r    <= S_MUL_HI;
        end

        S_MUL_HI: begin
          // dividend 2*delta*100000 + p over divisor 2*p rounds half up
          div_q_r   <= acc_r + (DIV_W'(prod_hi) << (CNT_W/2 + 1));
          div_rem_r <= '0;
          div_dsr_r <= {p_eff, 1'b0};
          div_cnt_r <= DCNT_W'(DIV_W);
          state_r   <= S_DIV_RATE;
        end

        S_DIV_RATE: begin
          div_q_r   <= div_q_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r - DCNT_W'(1);
          if (div_cnt_r == DCNT_W'(1)) begin
            state_r <= S_HIST_WR;
          end
        end

        S_HIST_WR: begin
          rate_r[ch_r] <= rate_v;
          sum_r        <= '0;
          sum_idx_r    <= '0;
          pend_r       <= 1'b0;
          state_r      <= S_SUM;
        end

        S_SUM: begin
          // issue one history read a cycle, add the previous one's data
          pend_r <= (sum_idx_r < fill_r);
          if (sum_idx_r < fill_r) begin
            sum_idx_r <= sum_idx_r + FW'(1);
          end
          if (pend_r) begin
            sum_r <= sum_r + SW'(hist_rd_r);
          end
          if ((sum_idx_r == fill_r) && !pend_r) begin
            if (fill_r == '0) begin
              avg_r[ch_r] <= '0;
              ch_r        <= ch_r + 2'd1;
              state_r     <= (ch_r == 2'd3) ? S_DONE : S_PREV;
            end else begin
              div_q_r   <= DIV_W'(sum_r) << (DIV_W - SW);
              div_rem_r <= '0;
              div_dsr_r <= DSR_W'(fill_r);
              div_cnt_r <= DCNT_W'(SW);
              state_r   <= S_DIV_AVG;
            end
          end
        end

        S_DIV_AVG: begin
          div_q_r   <= div_q_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r - DCNT_W'(1);
          if (div_cnt_r == DCNT_W'(1)) begin
            avg_r[ch_r] <= div_q_nxt[RATE_W-1:0];
            ch_r        <= ch_r + 2'd1;
            state_r     <= (ch_r == 2'd3) ? S_DONE : S_PREV;
          end
        end

        S_DONE: begin
          // park the result, then advance the ring on a round end
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_nic_r   <= nic_r;
            for (int i = 0; i < 4; i++) begin
              out_rate_r[i] <= rate_r[i];
              out_avg_r[i]  <= avg_r[i];
            end
            if (round_end_r) begin
              if (fill_r != '0) begin
                pos_r <= (pos_inc >= w_eff) ? '0 : PW'(pos_inc);
              end
              if (fill_r < w_eff) begin
                fill_r <= fill_r + FW'(1);
              end
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_nic_index         = out_nic_r;
  assign out_recv_bytes_rate   = out_rate_r[0];
  assign out_recv_packets_rate = out_rate_r[1];
  assign out_send_bytes_rate   = out_rate_r[2];
  assign out_send_packets_rate = out_rate_r[3];
  assign out_recv_bytes_avg    = out_avg_r[0];
  assign out_recv_packets_avg  = out_avg_r[1];
  assign out_send_bytes_avg    = out_avg_r[2];
  assign out_send_packets_avg  = out_avg_r[3];

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= WINDOW_MAX)
    else $error("fill count beyond window maximum");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < WINDOW_MAX)
    else $error("ring position beyond window maximum");

  a_sum_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (sum_idx_r <= fill_r))
    else $error("history read index passed fill count");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_DIV_RATE) && (state_r != S_DIV_AVG) && (state_r != S_MUL_HI))
      |=> ((state_r != S_DIV_RATE && state_r != S_DIV_AVG) || div_cnt_r != '0))
    else $error("divider running with exhausted step count");

  a_park: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not parked in output register");
`endif

endmodule
